[design/cpu_load_window_averager_unit_macros.svh]
// Assertion macros shared by the load window averager RTL.
`ifndef CPU_LOAD_WINDOW_AVERAGER_UNIT_MACROS_SVH
`define CPU_LOAD_WINDOW_AVERAGER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CLWA_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("clwa: implication check failed");
// Next-cycle implication, disabled during reset.
`define CLWA_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("clwa: next-cycle check failed");
`else
`define CLWA_ASSERT_IMP(lbl, clk, rst, a, b)
`define CLWA_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

[design/clwa_pkg.sv]
// Types and constants of the CPU load window averager.
`default_nettype none
package clwa_pkg;

  localparam int TICK_BITS  = 40;
  localparam int TOTAL_W    = TICK_BITS + 1;
  localparam int SCALE_BITS = 14;
  localparam int HIST_DEPTH = 15;
  localparam int IDX_W      = 4;
  localparam int SUM_W      = 18;

  localparam logic [SCALE_BITS-1:0] LOAD_SCALE = 14'd10000;

  // reciprocal constants: floor(x / n) == (x * RECIP) >> SHIFT over the sum range
  localparam logic [18:0] RECIP5   = 19'd52429;
  localparam logic [18:0] RECIP10  = 19'd104858;
  localparam logic [18:0] RECIP15  = 19'd279621;
  localparam int          SHIFT5   = 18;
  localparam int          SHIFT10  = 20;
  localparam int          SHIFT15  = 22;

  localparam logic [IDX_W-1:0] SPAN5  = 4'd5;
  localparam logic [IDX_W-1:0] SPAN10 = 4'd10;
  localparam logic [IDX_W-1:0] SPAN15 = 4'd15;

  typedef struct packed {
    logic [TICK_BITS-1:0] idle_ticks;
    logic [TICK_BITS-1:0] kernel_ticks;
    logic [TICK_BITS-1:0] user_ticks;
  } sample_t;

  typedef struct packed {
    logic [13:0] load_centi;
    logic        no_time_flag;
    logic [13:0] mean5_centi;
    logic        mean5_valid;
    logic [13:0] mean10_centi;
    logic        mean10_valid;
    logic [13:0] mean15_centi;
    logic        mean15_valid;
  } result_t;

  // status of the history unit towards the sequencer
  typedef struct packed {
    logic        busy;
    logic [13:0] mean5;
    logic        mean5_valid;
    logic [13:0] mean10;
    logic        mean10_valid;
    logic [13:0] mean15;
    logic        mean15_valid;
  } hist_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_RUN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[design/clwa_divider.sv]
// Iterative shift/subtract unit for floor(10000 * busy / total).
`default_nettype none
module clwa_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [clwa_pkg::TOTAL_W-1:0] numer,
  input  wire logic [clwa_pkg::TOTAL_W-1:0] denom,
  output logic                              busy,
  output logic [clwa_pkg::SCALE_BITS-1:0]   quot
);
  import clwa_pkg::*;

  localparam int REM_W = TOTAL_W + 1;

  logic [REM_W-1:0]      rem, rem_next, cand;
  logic [REM_W:0]        diff;
  logic [SCALE_BITS-1:0] q_next;
  logic [3:0]            bit_idx;
  logic                  add_phase;
  logic                  ge;

  // one shared subtract/compare: either doubled remainder or remainder plus numerator
  always_comb begin
    cand     = add_phase ? rem + {1'b0, numer} : {rem[REM_W-2:0], 1'b0};
    diff     = {1'b0, cand} - {2'b00, denom};
    ge       = ~diff[REM_W];
    rem_next = ge ? diff[REM_W-1:0] : cand;
    q_next   = (add_phase ? quot : {quot[SCALE_BITS-2:0], 1'b0})
               + {{(SCALE_BITS-1){1'b0}}, ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      add_phase <= 1'b0;
      bit_idx   <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      add_phase <= 1'b0;
      bit_idx   <= 4'(SCALE_BITS - 1);
    end else if (busy) begin
      if (!add_phase && LOAD_SCALE[bit_idx]) begin
        add_phase <= 1'b1;
      end else if (bit_idx == '0) begin
        busy      <= 1'b0;
        add_phase <= 1'b0;
      end else begin
        bit_idx   <= bit_idx - 4'd1;
        add_phase <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= q_next;
    end
  end

endmodule
`default_nettype wire

[design/clwa_history.sv]
// Fifteen-entry load history with sequential window sums and means.
`default_nettype none
module clwa_history (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          wr_en,
  input  wire logic [clwa_pkg::SCALE_BITS-1:0] wr_data,
  output clwa_pkg::hist_status_t             status
);
  import clwa_pkg::*;

  logic [SCALE_BITS-1:0] hist [HIST_DEPTH];
  logic [IDX_W-1:0]      wr_pos, items_seen, rd_idx;
  logic [4:0]            k;
  logic [4:0]            rd_sum;
  logic                  run;
  logic [SUM_W-1:0]      acc;
  logic [18:0]           recip;
  logic [SUM_W+18:0]     prod;
  logic [SCALE_BITS-1:0] mean5, mean10, mean15, mean_val;

  // slot of the k-th newest stored load
  always_comb begin
    rd_sum = {1'b0, wr_pos} + 5'(HIST_DEPTH) - k;
    rd_idx = (rd_sum >= 5'(HIST_DEPTH)) ? rd_sum[IDX_W-1:0] - 4'(HIST_DEPTH)
                                        : rd_sum[IDX_W-1:0];
  end

  // one multiplier, reused for the three window lengths
  always_comb begin
    case (k)
      5'd6:    recip = RECIP5;
      5'd11:   recip = RECIP10;
      default: recip = RECIP15;
    endcase
    prod = acc * recip;
    case (k)
      5'd6:    mean_val = prod[SHIFT5 +: SCALE_BITS];
      5'd11:   mean_val = prod[SHIFT10 +: SCALE_BITS];
      default: mean_val = prod[SHIFT15 +: SCALE_BITS];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      k   <= '0;
    end else if (start) begin
      run <= 1'b1;
      k   <= 5'd1;
    end else if (run) begin
      if (k == 5'd16) run <= 1'b0;
      k <= k + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (run) begin
      if (k <= 5'(HIST_DEPTH)) acc <= acc + {4'b0000, hist[rd_idx]};
      if (k == 5'd6)  mean5  <= mean_val;
      if (k == 5'd11) mean10 <= mean_val;
      if (k == 5'd16) mean15 <= mean_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) hist[wr_pos] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos     <= '0;
      items_seen <= '0;
    end else if (wr_en) begin
      wr_pos <= (wr_pos == 4'(HIST_DEPTH - 1)) ? '0 : wr_pos + 4'd1;
      if (items_seen != 4'(HIST_DEPTH)) items_seen <= items_seen + 4'd1;
    end
  end

  always_comb begin
    status.busy         = run;
    status.mean5_valid  = items_seen >= SPAN5;
    status.mean10_valid = items_seen >= SPAN10;
    status.mean15_valid = items_seen >= SPAN15;
    status.mean5        = status.mean5_valid  ? mean5  : '0;
    status.mean10       = status.mean10_valid ? mean10 : '0;
    status.mean15       = status.mean15_valid ? mean15 : '0;
  end

endmodule
`default_nettype wire

[design/cpu_load_window_averager_unit.sv]
// Top level of the CPU load window averager: sequencer and result register.
//
// Each sample beat carries one interval's idle, kernel and user tick deltas
// (kernel already includes idle). The result beat gives the busy share
// floor(10000 * (kernel + user - idle) / (kernel + user)) in hundredths of a
// percent, with no_time_flag set and load 0 when kernel + user is zero, and
// load 0 when idle exceeds the total. Alongside it come the truncated means of
// the previous 5, 10 and 15 loads (the current one excluded); each mean field
// is 0 until its valid bit shows that enough earlier loads are stored. One
// sample is processed at a time: the next is taken only after the previous
// result has gone into the result register. Most of the work is done by the
// divider's shared subtract/compare loop, with 14 doubling steps plus 5 add
// steps, one per cycle, for the set bits of 10000. Operand set-up and
// divider start come before it; hand-over to the done state and the result
// register load come after it. The window sums run in parallel on one adder
// and one reciprocal multiplier. The result register decouples the two
// sides, so the next sample is taken while a finished result still waits.
// History contents are undefined after reset but never reach an output
// before being written.
`default_nettype none
`include "cpu_load_window_averager_unit_macros.svh"
module cpu_load_window_averager_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire clwa_pkg::sample_t sample,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output clwa_pkg::result_t      result
);
  import clwa_pkg::*;

  state_t state, state_next;

  logic [TOTAL_W-1:0]    total_r, busy_r;
  logic [TICK_BITS-1:0]  idle_r;
  logic [TOTAL_W:0]      busy_diff;
  logic                  no_time_r, zero_load_r;
  logic                  accept, prep, deliver;
  logic                  prep_q;
  logic                  div_busy;
  logic [SCALE_BITS-1:0] quot, load_val;
  hist_status_t          hist_st;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign prep         = (state == S_PREP);
  // result register free, or emptied at this very edge
  assign deliver      = (state == S_DONE) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_PREP;
      S_PREP:  state_next = S_RUN;
      S_RUN:   if (!div_busy && !hist_st.busy) state_next = S_DONE;
      S_DONE:  if (deliver) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // total keeps its carry bit; busy = total - idle, borrow flags idle above total
  assign busy_diff = {1'b0, total_r} - {2'b00, idle_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      total_r <= {1'b0, sample.kernel_ticks} + {1'b0, sample.user_ticks};
      idle_r  <= sample.idle_ticks;
    end
    if (prep) begin
      busy_r      <= busy_diff[TOTAL_W-1:0];
      no_time_r   <= (total_r == '0);
      zero_load_r <= (total_r == '0) || busy_diff[TOTAL_W];
    end
  end

  // divider starts in the cycle after set-up, once busy_r is loaded
  always_ff @(posedge clk) begin
    if (rst) prep_q <= 1'b0;
    else     prep_q <= prep;
  end

  clwa_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (prep_q),
    .numer (busy_r),
    .denom (total_r),
    .busy  (div_busy),
    .quot  (quot)
  );

  clwa_history u_hist (
    .clk     (clk),
    .rst     (rst),
    .start   (prep),
    .wr_en   (deliver),
    .wr_data (load_val),
    .status  (hist_st)
  );

  always_comb begin
    if (zero_load_r)             load_val = '0;
    else if (quot > LOAD_SCALE)  load_val = LOAD_SCALE;
    else                         load_val = quot;
  end

  always_ff @(posedge clk) begin
    if (rst)               result_valid <= 1'b0;
    else if (deliver)      result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      result.load_centi   <= load_val;
      result.no_time_flag <= no_time_r;
      result.mean5_centi  <= hist_st.mean5;
      result.mean5_valid  <= hist_st.mean5_valid;
      result.mean10_centi <= hist_st.mean10;
      result.mean10_valid <= hist_st.mean10_valid;
      result.mean15_centi <= hist_st.mean15;
      result.mean15_valid <= hist_st.mean15_valid;
    end
  end

  `CLWA_ASSERT_IMP(a_no_time_zero, clk, rst, result_valid && result.no_time_flag, result.load_centi == '0)
  `CLWA_ASSERT_IMP(a_load_range, clk, rst, result_valid, result.load_centi <= LOAD_SCALE)
  `CLWA_ASSERT_IMP(a_valid_nest, clk, rst, result_valid && result.mean15_valid, result.mean10_valid && result.mean5_valid)
  `CLWA_ASSERT_IMP(a_done_quiet, clk, rst, state == S_DONE, !div_busy && !hist_st.busy)
  `CLWA_ASSERT_NXT(a_div_starts, clk, rst, prep_q, div_busy)

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the CPU load window averager: ready/valid driver, monitor and predictor.
module tb;
  import clwa_pkg::*;

  localparam int PERIOD_NS     = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 700;
  localparam int TAIL_CYCLES   = 40;      // a little beyond the sample-to-result time
  localparam int CYCLE_LIMIT   = 400000;  // cycle limit for the watchdog
  localparam int PHASE1_AT     = 250;     // issued-beat counts at which the idling phase changes
  localparam int PHASE2_AT     = 500;
  localparam int DRAIN_AT_A    = 150;     // sender holds off here until all results are back
  localparam int DRAIN_AT_B    = 420;
  localparam int MAX_REPORTS   = 60;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_ready;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  cpu_load_window_averager_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #(PERIOD_NS / 2) clk = ~clk;
  end

  // Predictor state: own copy of the load history and its fill level.
  logic [13:0]      load_ring [HIST_DEPTH];
  logic [IDX_W-1:0] ring_wr_idx = '0;
  logic [IDX_W-1:0] loads_stored = '0;

  sample_t pending_samples[$];
  result_t expected_results[$];

  // Beat counters n_issued, n_accepted and n_done are updated with nonblocking
  // assignments so every reader sees the pre-edge value whatever the process order.
  int n_issued    = 0;
  int n_accepted  = 0;
  int n_done      = 0;
  int n_errors    = 0;
  int total_items = 0;
  int cycle_count = 0;

  // Truncated mean of the last 'span' stored loads.
  function automatic logic [13:0] window_mean(int span);
    int unsigned sum;
    int          slot;
    sum = 0;
    for (int k = 1; k <= span; k++) begin
      slot = (int'(ring_wr_idx) + HIST_DEPTH - k) % HIST_DEPTH;
      sum += load_ring[slot];
    end
    return 14'(sum / span);
  endfunction

  // Works out the result beat for one accepted sample, then pushes the new
  // load into the history ring. Means cover earlier loads only.
  function automatic result_t compute_load_result(sample_t s);
    result_t     r;
    logic [63:0] total;
    logic [63:0] idle;
    logic [63:0] scaled_busy;
    logic [13:0] load;
    total = {24'd0, s.kernel_ticks} + {24'd0, s.user_ticks};  // keeps the carry bit
    idle  = {24'd0, s.idle_ticks};
    load  = '0;
    r     = '0;
    if (total == 64'd0) begin
      r.no_time_flag = 1'b1;           // nothing elapsed: load forced to zero
    end else if (total >= idle) begin
      scaled_busy = (total - idle) * 64'd10000;
      load = 14'(scaled_busy / total);
    end                                 // idle above total: load stays zero
    r.load_centi   = load;
    r.mean5_valid  = loads_stored >= SPAN5;
    r.mean10_valid = loads_stored >= SPAN10;
    r.mean15_valid = loads_stored >= SPAN15;
    if (r.mean5_valid)  r.mean5_centi  = window_mean(5);
    if (r.mean10_valid) r.mean10_centi = window_mean(10);
    if (r.mean15_valid) r.mean15_centi = window_mean(15);
    load_ring[ring_wr_idx] = load;
    ring_wr_idx = (ring_wr_idx == IDX_W'(HIST_DEPTH - 1)) ? '0 : ring_wr_idx + 1'b1;
    if (loads_stored != IDX_W'(HIST_DEPTH)) loads_stored = loads_stored + 1'b1;
    return r;
  endfunction

  // Tick count with a random significant width, so small and huge values mix.
  function automatic logic [TICK_BITS-1:0] random_ticks();
    logic [63:0]        raw;
    logic [TICK_BITS:0] mask;
    int                 nbits;
    raw   = {$urandom, $urandom};
    nbits = $urandom_range(TICK_BITS, 0);
    mask  = (41'd1 << nbits) - 41'd1;
    return raw[TICK_BITS-1:0] & mask[TICK_BITS-1:0];
  endfunction

  function automatic logic [TICK_BITS-1:0] full_width_ticks();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[TICK_BITS-1:0];
  endfunction

  function automatic sample_t make_sample(logic [TICK_BITS-1:0] idle, kern, usr);
    sample_t s;
    s.idle_ticks   = idle;
    s.kernel_ticks = kern;
    s.user_ticks   = usr;
    return s;
  endfunction

  // One random sample. Most are plausible intervals (idle within kernel time),
  // the rest hit full load, all-idle, zero total, idle above total and noise.
  function automatic sample_t random_sample();
    logic [TICK_BITS-1:0] kern, usr, idle;
    logic [63:0]          raw;
    int                   pick;
    pick = $urandom_range(99);
    kern = random_ticks();
    usr  = random_ticks();
    raw  = {$urandom, $urandom};
    idle = TICK_BITS'(raw % ({24'd0, kern} + 64'd1));
    if (pick < 60) begin
      return make_sample(idle, kern, usr);
    end else if (pick < 68) begin
      return make_sample('0, kern, usr);
    end else if (pick < 76) begin
      return make_sample(kern, kern, usr);
    end else if (pick < 88) begin
      return make_sample(full_width_ticks(), full_width_ticks(), full_width_ticks());
    end else if (pick < 94) begin
      return make_sample(random_ticks(), '0, '0);
    end else begin
      // idle strictly above kernel + user
      kern = kern >> 2;
      usr  = usr >> 2;
      return make_sample(kern + usr + 1'b1 + (random_ticks() >> 1), kern, usr);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Idling percentages per phase: sender light / receiver heavy, then swapped,
  // then no idling on either side.
  function automatic int sender_idle_pct(int issued);
    if (issued < PHASE1_AT) return 23;
    if (issued < PHASE2_AT) return 71;
    return 0;
  endfunction

  function automatic int receiver_stall_pct(int issued);
    if (issued < PHASE1_AT) return 71;
    if (issued < PHASE2_AT) return 23;
    return 0;
  endfunction

  // Sample driver. Valid stays up with a steady payload until the beat is
  // taken; a new beat is only offered once the previous one has gone.
  always @(posedge clk) begin : sample_driver
    bit fire;
    bit offer;
    int accepted_now;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      fire = sample_valid && sample_ready;
      if (fire) begin
        expected_results.push_back(compute_load_result(sample));
        n_accepted <= n_accepted + 1;
      end
      accepted_now = n_accepted + (fire ? 1 : 0);
      if (!sample_valid || fire) begin
        offer = pending_samples.size() != 0;
        // drain points: hold off until every outstanding result has come back
        if ((n_issued == DRAIN_AT_A || n_issued == DRAIN_AT_B) && accepted_now != n_done)
          offer = 1'b0;
        if ($urandom_range(99) < sender_idle_pct(n_issued))
          offer = 1'b0;
        if (offer) begin
          sample   <= pending_samples.pop_front();
          n_issued <= n_issued + 1;
        end
        sample_valid <= offer;
      end
    end
  end

  // Result monitor: compares each taken beat against the oldest prediction
  // and applies random back-pressure.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t ns: result beat with nothing expected, actual %h", $time, result);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("load_centi",   want.load_centi,   result.load_centi);
          check_field("no_time_flag", want.no_time_flag, result.no_time_flag);
          check_field("mean5_centi",  want.mean5_centi,  result.mean5_centi);
          check_field("mean5_valid",  want.mean5_valid,  result.mean5_valid);
          check_field("mean10_centi", want.mean10_centi, result.mean10_centi);
          check_field("mean10_valid", want.mean10_valid, result.mean10_valid);
          check_field("mean15_centi", want.mean15_centi, result.mean15_centi);
          check_field("mean15_valid", want.mean15_valid, result.mean15_valid);
          n_done <= n_done + 1;
        end
      end
      result_ready <= ($urandom_range(99) >= receiver_stall_pct(n_issued));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL cpu_load_window_averager_unit");
      $finish;
    end
  end

  initial begin
    // Directed beats: zero total (with and without idle), idle above total,
    // idle equal to total, full load with the carry out of kernel + user,
    // truncation cases and alternating bit patterns.
    pending_samples.push_back(make_sample('0, '0, '0));
    pending_samples.push_back(make_sample(TICK_MAX, '0, '0));
    pending_samples.push_back(make_sample('0, '0, TICK_MAX));
    pending_samples.push_back(make_sample(TICK_MAX, TICK_MAX, TICK_MAX));
    pending_samples.push_back(make_sample(TICK_MAX, TICK_MAX, '0));
    pending_samples.push_back(make_sample(TICK_MAX, 40'd1, 40'd1));
    pending_samples.push_back(make_sample(40'd1, 40'd3, '0));
    pending_samples.push_back(make_sample(TICK_MAX - 1'b1, TICK_MAX, '0));
    pending_samples.push_back(make_sample(40'd1, TICK_MAX, TICK_MAX));
    pending_samples.push_back(make_sample(40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h55_5555_5555));
    // a run at full load so every window mean reaches its top value
    for (int k = 0; k < HIST_DEPTH; k++)
      pending_samples.push_back(make_sample('0, random_ticks() | 40'd1, random_ticks()));
    for (int k = 0; k < RANDOM_ITEMS; k++)
      pending_samples.push_back(random_sample());
    total_items = pending_samples.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // n_done only counts matched results, so this covers every beat
    while (n_done != total_items) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASS cpu_load_window_averager_unit");
    end else begin
      $display("FAIL cpu_load_window_averager_unit");
    end
    $finish;
  end

endmodule
